[rtl/voxel_exposed_face_mask_macros.svh]
// ----------------------------------------------------------------------------
// Voxel exposed face mask: assertion macros
// Shared forms of the concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef VOXEL_EXPOSED_FACE_MASK_MACROS_SVH
`define VOXEL_EXPOSED_FACE_MASK_MACROS_SVH

// Assertion that is switched off while reset is high.
`define VEFM_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked while reset is high.
`define VEFM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/vefm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel exposed face mask package
// Field widths, operation and side codes, and default chunk size.
// ----------------------------------------------------------------------------
package vefm_pkg;

  localparam int DEFAULT_CHUNK_EDGE = 16;

  localparam int OP_W     = 2;
  localparam int COORD_W  = 4;
  localparam int COLOUR_W = 8;
  localparam int SIDE_W   = 3;
  localparam int WORD_W   = 16;
  localparam int SIDES    = 6;

  localparam logic [OP_W-1:0] OP_WRITE_COLOUR = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_PLANE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY        = 2'd2;

  localparam logic [SIDE_W-1:0] SIDE_PX = 3'd0;
  localparam logic [SIDE_W-1:0] SIDE_NX = 3'd1;
  localparam logic [SIDE_W-1:0] SIDE_PY = 3'd2;
  localparam logic [SIDE_W-1:0] SIDE_NY = 3'd3;
  localparam logic [SIDE_W-1:0] SIDE_PZ = 3'd4;
  localparam logic [SIDE_W-1:0] SIDE_NZ = 3'd5;
  // Selects the voxel itself rather than one of its neighbours.
  localparam logic [SIDE_W-1:0] SEL_CENTER = 3'd6;

  localparam logic [WORD_W-1:0] WORD_NOT_SURFACE = 16'h0001;

endpackage

[rtl/vefm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel exposed face mask channels
// Valid/ready interfaces for the item input and the result output.
// ----------------------------------------------------------------------------
interface vefm_item_if;
  logic                           valid;
  logic                           ready;
  logic [vefm_pkg::OP_W-1:0]      op;
  logic [vefm_pkg::COORD_W-1:0]   x_coord;
  logic [vefm_pkg::COORD_W-1:0]   y_coord;
  logic [vefm_pkg::COORD_W-1:0]   z_coord;
  logic [vefm_pkg::COLOUR_W-1:0]  voxel_colour;
  logic [vefm_pkg::SIDE_W-1:0]    side;
  logic                           plane_empty;

  modport source (output valid, op, x_coord, y_coord, z_coord, voxel_colour, side,
                  plane_empty, input ready);
  modport sink (input valid, op, x_coord, y_coord, z_coord, voxel_colour, side,
                plane_empty, output ready);
endinterface

interface vefm_result_if;
  logic                          valid;
  logic                          ready;
  logic [vefm_pkg::WORD_W-1:0]   result_word;
  logic                          is_surface;

  modport source (output valid, result_word, is_surface, input ready);
  modport sink (input valid, result_word, is_surface, output ready);
endinterface

[rtl/vefm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel exposed face mask RAM
// Synchronous RAM with one read/write port and one read port, registered reads.
// ----------------------------------------------------------------------------
module vefm_ram #(
  parameter int DW = 8,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          a_we,
  input  logic [AW-1:0] a_addr,
  input  logic [DW-1:0] a_wdata,
  output logic [DW-1:0] a_rdata,
  input  logic [AW-1:0] b_addr,
  output logic [DW-1:0] b_rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (a_we) begin
      mem[a_addr] <= a_wdata;
    end
    a_rdata <= mem[a_addr];
    b_rdata <= mem[b_addr];
  end

endmodule

[rtl/voxel_exposed_face_mask.sv]
`timescale 1ns / 1ps
// A query beat is accepted in the idle state; the colour reads are then issued in RD0 to
// RD3, and the result is formed in ST_FIN, left only once the result register is free.
// No new item beat is taken until the query is back in idle. The seven colour reads
// use both ports of the colour RAM; colour and plane writes are taken in the idle state.
// Reset (rst, synchronous, active high) clears the sequencer, the output valid and
// neighbour_present; the memories are not cleared and must be written before use.
// ----------------------------------------------------------------------------
// Voxel exposed face mask
// Holds one voxel chunk and six neighbour boundary planes, and answers queries
// with the colour and the mask of exposed faces of one voxel, or a marker word when it is no surface.
// ----------------------------------------------------------------------------
module voxel_exposed_face_mask #(
  parameter int CHUNK_EDGE = vefm_pkg::DEFAULT_CHUNK_EDGE
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  vefm_item_if.sink  item_in,
  vefm_result_if.source result_out
);
  import vefm_pkg::*;

  // Each coordinate is stored in CW bits, so the memories are padded up to a
  // power of two along every axis. Padding entries are never queried.
  localparam int CW     = $clog2(CHUNK_EDGE);
  localparam int CAW    = 3 * CW;
  localparam int PAW    = SIDE_W + 2 * CW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_FIN
  } state_t;

  state_t state;

  logic [SIDES-1:0]    neighbour_present;
  logic [CW-1:0]       cx, cy, cz;
  logic                query_ok;
  logic [SIDES-1:0]    edge_hit;
  logic [COLOUR_W-1:0] colour;
  logic [SIDES-2:0]    mask;
  logic                out_valid;
  logic [WORD_W-1:0]   out_word;
  logic                out_surface;

  logic                accept;
  logic [SIDE_W-1:0]   a_sel, b_sel;
  logic                c_we, p_we;
  logic [CAW-1:0]      c_a_addr, c_b_addr;
  logic [PAW-1:0]      p_a_addr, p_b_addr;
  logic [COLOUR_W-1:0] c_a_rdata, c_b_rdata;
  logic                p_a_rdata, p_b_rdata;
  logic                x_in, y_in, z_in;
  logic                plane_ok;
  logic                open_last;
  logic [SIDES-1:0]    face_mask;
  logic                surface;

  // A coordinate addresses the chunk only when it is below the edge length.
  function automatic logic in_range(input logic [COORD_W-1:0] c);
    return 32'(c) < CHUNK_EDGE;
  endfunction

  function automatic logic [CW-1:0] narrow(input logic [COORD_W-1:0] c);
    logic [CW+COORD_W-1:0] e;
    e = {{CW{1'b0}}, c};
    return e[CW-1:0];
  endfunction

  // Colour address of the voxel or of one of its six neighbours. A neighbour
  // beyond the chunk edge wraps to some entry whose data is then ignored.
  function automatic logic [CAW-1:0] cell_addr(input logic [SIDE_W-1:0] sel,
                                               input logic [CW-1:0] x,
                                               input logic [CW-1:0] y,
                                               input logic [CW-1:0] z);
    logic [CW-1:0] nx, ny, nz;
    nx = x;
    ny = y;
    nz = z;
    case (sel)
      SIDE_PX: nx = x + CW'(1);
      SIDE_NX: nx = x - CW'(1);
      SIDE_PY: ny = y + CW'(1);
      SIDE_NY: ny = y - CW'(1);
      SIDE_PZ: nz = z + CW'(1);
      SIDE_NZ: nz = z - CW'(1);
      default: nx = x;
    endcase
    return {nx, ny, nz};
  endfunction

  // Plane address: the side and the two coordinates across its axis.
  function automatic logic [PAW-1:0] plane_addr(input logic [SIDE_W-1:0] s,
                                                input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
    logic [PAW-1:0] a;
    case (s)
      SIDE_PX, SIDE_NX: a = {s, y, z};
      SIDE_PY, SIDE_NY: a = {s, x, z};
      default:          a = {s, x, y};
    endcase
    return a;
  endfunction

  // An edge face is open when the neighbour chunk exists and its boundary voxel
  // is empty; an inner face is open when the neighbouring voxel is empty.
  function automatic logic face_open(input logic on_edge, input logic present,
                                     input logic plane_bit,
                                     input logic [COLOUR_W-1:0] nb);
    return on_edge ? (present & plane_bit) : (nb == '0);
  endfunction

  assign accept = item_in.valid && item_in.ready;
  // No beat is taken while reset is held.
  assign item_in.ready = (state == ST_IDLE) && !rst;

  assign x_in = in_range(item_in.x_coord);
  assign y_in = in_range(item_in.y_coord);
  assign z_in = in_range(item_in.z_coord);

  // The coordinate along the side's own axis does not address the plane.
  always_comb begin
    plane_ok = 1'b0;
    case (item_in.side[SIDE_W-1:1])
      2'd0:    plane_ok = y_in && z_in;
      2'd1:    plane_ok = x_in && z_in;
      2'd2:    plane_ok = x_in && y_in;
      default: plane_ok = 1'b0;
    endcase
  end

  // Read schedule: the voxel and +x, then -x and +y, -y and +z, and last -z on both ports.
  // Port B of the plane RAM follows port B of the colour RAM, likewise port A.
  always_comb begin
    case (state)
      ST_RD0: begin
        a_sel = SEL_CENTER;
        b_sel = SIDE_PX;
      end
      ST_RD1: begin
        a_sel = SIDE_NX;
        b_sel = SIDE_PY;
      end
      ST_RD2: begin
        a_sel = SIDE_NY;
        b_sel = SIDE_PZ;
      end
      ST_RD3, ST_FIN: begin
        a_sel = SIDE_NZ;
        b_sel = SIDE_NZ;
      end
      default: begin
        a_sel = SEL_CENTER;
        b_sel = SEL_CENTER;
      end
    endcase
  end

  // Writes use port A while the block is idle; memory writes land at the
  // accepting edge, so a following query always sees them.
  always_comb begin
    c_we = accept && (item_in.op == OP_WRITE_COLOUR) && x_in && y_in && z_in;
    p_we = accept && (item_in.op == OP_WRITE_PLANE) && (32'(item_in.side) < SIDES)
           && plane_ok;
    if (state == ST_IDLE) begin
      c_a_addr = cell_addr(SEL_CENTER, narrow(item_in.x_coord), narrow(item_in.y_coord),
                           narrow(item_in.z_coord));
      p_a_addr = plane_addr(item_in.side, narrow(item_in.x_coord),
                            narrow(item_in.y_coord), narrow(item_in.z_coord));
    end else begin
      c_a_addr = cell_addr(a_sel, cx, cy, cz);
      p_a_addr = plane_addr(a_sel, cx, cy, cz);
    end
    c_b_addr = cell_addr(b_sel, cx, cy, cz);
    p_b_addr = plane_addr(b_sel, cx, cy, cz);
  end

  vefm_ram #(
    .DW(COLOUR_W),
    .AW(CAW)
  ) u_colour_ram (
    .clk     (clk),
    .a_we    (c_we),
    .a_addr  (c_a_addr),
    .a_wdata (item_in.voxel_colour),
    .a_rdata (c_a_rdata),
    .b_addr  (c_b_addr),
    .b_rdata (c_b_rdata)
  );

  vefm_ram #(
    .DW(1),
    .AW(PAW)
  ) u_plane_ram (
    .clk     (clk),
    .a_we    (p_we),
    .a_addr  (p_a_addr),
    .a_wdata (item_in.plane_empty),
    .a_rdata (p_a_rdata),
    .b_addr  (p_b_addr),
    .b_rdata (p_b_rdata)
  );

  // The -z face arrives last and is folded in directly when the result is formed.
  // Read addresses hold in the final state, so this data holds through a stall.
  always_comb begin
    open_last = face_open(edge_hit[SIDES-1], neighbour_present[SIDES-1], p_a_rdata,
                          c_a_rdata);
    face_mask = {open_last, mask};
    surface   = query_ok && (colour != '0) && (face_mask != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      neighbour_present <= '0;
    end else begin
      if (cfg_we) begin
        neighbour_present <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (item_in.op == OP_QUERY)) begin
            state <= ST_RD0;
          end
        end
        ST_RD0: state <= ST_RD1;
        ST_RD1: state <= ST_RD2;
        ST_RD2: state <= ST_RD3;
        ST_RD3: state <= ST_FIN;
        ST_FIN: begin
          // The result register is free when empty or emptied in this cycle.
          if (!out_valid || result_out.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // The result register loads in the final state once it is free, and
      // otherwise empties when its beat is taken.
      if ((state == ST_FIN) && (!out_valid || result_out.ready)) begin
        out_valid   <= 1'b1;
        out_surface <= surface;
        out_word    <= surface ? {colour, face_mask, 2'b00} : WORD_NOT_SURFACE;
      end else if (out_valid && result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Query payload and face accumulation; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      cx       <= narrow(item_in.x_coord);
      cy       <= narrow(item_in.y_coord);
      cz       <= narrow(item_in.z_coord);
      query_ok <= x_in && y_in && z_in;
      edge_hit <= {32'(item_in.z_coord) == 0, 32'(item_in.z_coord) == CHUNK_EDGE - 1,
                   32'(item_in.y_coord) == 0, 32'(item_in.y_coord) == CHUNK_EDGE - 1,
                   32'(item_in.x_coord) == 0, 32'(item_in.x_coord) == CHUNK_EDGE - 1};
    end
    case (state)
      ST_RD1: begin
        colour  <= c_a_rdata;
        mask[0] <= face_open(edge_hit[0], neighbour_present[0], p_b_rdata, c_b_rdata);
      end
      ST_RD2: begin
        mask[1] <= face_open(edge_hit[1], neighbour_present[1], p_a_rdata, c_a_rdata);
        mask[2] <= face_open(edge_hit[2], neighbour_present[2], p_b_rdata, c_b_rdata);
      end
      ST_RD3: begin
        mask[3] <= face_open(edge_hit[3], neighbour_present[3], p_a_rdata, c_a_rdata);
        mask[4] <= face_open(edge_hit[4], neighbour_present[4], p_b_rdata, c_b_rdata);
      end
      default: begin
      end
    endcase
  end

  assign result_out.valid       = out_valid;
  assign result_out.result_word = out_word;
  assign result_out.is_surface  = out_surface;

endmodule

[rtl/vefm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel exposed face mask port checker
// Watches the result port of the top level and checks its beats over time.
// ----------------------------------------------------------------------------
`include "voxel_exposed_face_mask_macros.svh"

module vefm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] result_word,
  input logic        is_surface
);

  // A stalled result beat holds.
  `VEFM_ASSERT_RST(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(result_word) && $stable(is_surface), "result beat changed while stalled")

  // A beat that is not a surface carries the plain marker word.
  `VEFM_ASSERT_RST(a_not_surface, clk, rst, out_valid && !is_surface |-> result_word == 16'h0001, "non-surface beat with wrong word")

  // A surface beat has a solid colour, an open face and clear low bits.
  `VEFM_ASSERT_RST(a_surface, clk, rst, out_valid && is_surface |-> result_word[1:0] == 2'b00 && result_word[7:2] != 6'd0 && result_word[15:8] != 8'd0, "malformed surface beat")

  // Reset empties the result register.
  `VEFM_ASSERT_ALWAYS(a_reset, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind voxel_exposed_face_mask vefm_checker u_vefm_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .result_word (result_out.result_word),
  .is_surface  (result_out.is_surface)
);

[tb/sv/tb_voxel_exposed_face_mask.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel exposed face mask testbench
// Drives colour writes, plane writes and queries into the chunk block with
// random gaps and result stalls. It keeps its own copy of the chunk, the
// boundary planes and the neighbour register, predicts each query word and
// compares every result beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_voxel_exposed_face_mask;
  import vefm_pkg::*;

  localparam int EDGE        = DEFAULT_CHUNK_EDGE;
  localparam int VOXELS      = EDGE * EDGE * EDGE;
  localparam int PLANE_BITS  = SIDES * EDGE * EDGE;
  // The limit allows every beat the longest sender gap, the longest result
  // stall and a full query.
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_REPORTS = 100;

  // Codes that the block must ignore: the unused operation and the two side
  // values that do not name a neighbour plane.
  localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
  localparam logic [SIDE_W-1:0] SIDE_BAD_LOW = 3'd6;
  localparam logic [SIDE_W-1:0] SIDE_BAD_TOP = 3'd7;

  // Face bit of side +x; side s owns this bit shifted left by s.
  localparam logic [7:0] FACE_PX_BIT = 8'h04;

  typedef struct {
    logic [WORD_W-1:0]  word;
    logic               surface;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } face_word_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [5:0] cfg_wdata;

  vefm_item_if   item_bus ();
  vefm_result_if result_bus ();

  voxel_exposed_face_mask #(
    .CHUNK_EDGE(EDGE)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_in   (item_bus),
    .result_out(result_bus)
  );

  // Our own copy of the chunk. The "set" arrays record which entries have been
  // written, so that no query ever reads an entry the block has not been given.
  logic [7:0] chunk_colour     [VOXELS];
  bit         chunk_colour_set [VOXELS];
  bit         border_empty     [PLANE_BITS];
  bit         border_set       [PLANE_BITS];
  logic [5:0] sides_present;

  face_word_t pending_faces[$];
  int         mismatches;
  int         useful_beats;
  int         cycle_count;
  int         ready_hold;
  int         hot_base;
  bit         no_idle;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The cycle counter ends a run that hangs, for example when a result never comes.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Predictor of the block
  // -------------------------------------------------------------------------

  function automatic int voxel_slot(input logic [COORD_W-1:0] x, y, z);
    return (int'(x) * EDGE + int'(y)) * EDGE + int'(z);
  endfunction

  // A plane is addressed by the two coordinates off the side's own axis.
  function automatic int plane_slot(input logic [SIDE_W-1:0] s,
                                    input logic [COORD_W-1:0] x, y, z);
    int a;
    int b;
    if (s < SIDE_PY) begin
      a = y;
      b = z;
    end else if (s < SIDE_PZ) begin
      a = x;
      b = z;
    end else begin
      a = x;
      b = y;
    end
    return int'(s) * EDGE * EDGE + a * EDGE + b;
  endfunction

  // Works out what a face of voxel x,y,z looks at. Returns 1 when the face lies
  // on the chunk edge, so the neighbour plane decides; otherwise the neighbour
  // voxel inside the chunk is returned in nx,ny,nz.
  function automatic bit face_read(input logic [SIDE_W-1:0] s,
                                   input logic [COORD_W-1:0] x, y, z,
                                   output logic [COORD_W-1:0] nx, ny, nz);
    logic [COORD_W-1:0] c [3];
    int                 ax;
    bit                 up;
    c[0] = x;
    c[1] = y;
    c[2] = z;
    ax = int'(s[2:1]);
    up = !s[0];
    nx = x;
    ny = y;
    nz = z;
    if (up ? (c[ax] == COORD_W'(EDGE - 1)) : (c[ax] == '0)) return 1'b1;
    if (up) c[ax] = c[ax] + 1'b1;
    else c[ax] = c[ax] - 1'b1;
    nx = c[0];
    ny = c[1];
    nz = c[2];
    return 1'b0;
  endfunction

  // An edge face is open only when that neighbour chunk exists and its
  // boundary voxel is empty; an absent neighbour covers the face.
  function automatic bit face_open(input logic [SIDE_W-1:0] s,
                                   input logic [COORD_W-1:0] x, y, z);
    logic [COORD_W-1:0] nx, ny, nz;
    bit                 on_edge;
    on_edge = face_read(s, x, y, z, nx, ny, nz);
    if (on_edge) return sides_present[s] && border_empty[plane_slot(s, x, y, z)];
    return chunk_colour[voxel_slot(nx, ny, nz)] == 8'd0;
  endfunction

  // -------------------------------------------------------------------------
  // Random choices
  // -------------------------------------------------------------------------

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // Many empty voxels so that faces open up, plus the colour extremes.
  function automatic logic [7:0] pick_colour();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'd0;
    if (r < 45) return 8'hFF;
    if (r < 50) return 8'h01;
    return 8'($urandom_range(255, 1));
  endfunction

  // Coordinates crowd on the chunk edges and in a small hot window so that
  // writes and queries keep landing on the same voxels.
  function automatic logic [COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 30) begin
      case ($urandom_range(3))
        0: return '0;
        1: return COORD_W'(1);
        2: return COORD_W'(EDGE - 2);
        default: return COORD_W'(EDGE - 1);
      endcase
    end
    if (r < 70) return COORD_W'(hot_base + $urandom_range(3));
    return COORD_W'($urandom_range(EDGE - 1));
  endfunction

  // -------------------------------------------------------------------------
  // Result side: random stalls on ready, and the checker
  // -------------------------------------------------------------------------

  always @(negedge clk) begin
    if (no_idle) begin
      result_bus.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      result_bus.ready <= 1'b0;
      ready_hold--;
    end else if ($urandom_range(99) < 25) begin
      ready_hold = pick_gap();
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("ERROR: cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Each accepted result beat is checked against the oldest predicted word.
  always @(posedge clk) begin
    face_word_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_faces.size() == 0) begin
        report_mismatch($sformatf("result beat word %h with no query outstanding",
                                  result_bus.result_word));
      end else begin
        want = pending_faces.pop_front();
        if (result_bus.result_word !== want.word)
          report_mismatch($sformatf("voxel %0d,%0d,%0d: result_word %h, predicted %h",
                                    want.x, want.y, want.z, result_bus.result_word,
                                    want.word));
        if (result_bus.is_surface !== want.surface)
          report_mismatch($sformatf("voxel %0d,%0d,%0d: is_surface %b, predicted %b",
                                    want.x, want.y, want.z, result_bus.is_surface,
                                    want.surface));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Item side
  // -------------------------------------------------------------------------

  // Sends one item beat after a random gap and, once the beat is accepted,
  // applies it to our copy of the chunk. A query queues its predicted word.
  // Valid stays high when the next beat follows with no gap.
  task automatic send_beat(input logic [OP_W-1:0] op,
                           input logic [COORD_W-1:0] x, y, z,
                           input logic [7:0] colour,
                           input logic [SIDE_W-1:0] s,
                           input logic empty);
    int         gap;
    int         slot;
    logic [7:0] centre;
    logic [7:0] mask;
    face_word_t want;
    gap = no_idle ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      item_bus.valid <= 1'b0;
    end
    @(negedge clk);
    item_bus.valid        <= 1'b1;
    item_bus.op           <= op;
    item_bus.x_coord      <= x;
    item_bus.y_coord      <= y;
    item_bus.z_coord      <= z;
    item_bus.voxel_colour <= colour;
    item_bus.side         <= s;
    item_bus.plane_empty  <= empty;
    forever begin
      @(posedge clk);
      if (item_bus.ready) break;
    end

    case (op)
      OP_WRITE_COLOUR: begin
        slot = voxel_slot(x, y, z);
        chunk_colour[slot]     = colour;
        chunk_colour_set[slot] = 1'b1;
        useful_beats++;
      end
      OP_WRITE_PLANE: begin
        // Side codes past -z name no plane and leave everything as it was.
        if (s < SIDES) begin
          slot = plane_slot(s, x, y, z);
          border_empty[slot] = empty;
          border_set[slot]   = 1'b1;
          useful_beats++;
        end
      end
      OP_QUERY: begin
        want.word    = WORD_NOT_SURFACE;
        want.surface = 1'b0;
        want.x       = x;
        want.y       = y;
        want.z       = z;
        centre = chunk_colour[voxel_slot(x, y, z)];
        // An empty voxel, or a solid one with every face covered, answers 1.
        if (centre != 8'd0) begin
          mask = '0;
          for (int k = 0; k < SIDES; k++)
            if (face_open(SIDE_W'(k), x, y, z)) mask |= FACE_PX_BIT << k;
          if (mask != '0) begin
            want.word    = {centre, mask};
            want.surface = 1'b1;
          end
        end
        pending_faces = {pending_faces, want};
        useful_beats++;
      end
      default: ;
    endcase
  endtask

  // Queries one voxel. Any entry that the query will read but that was never
  // written is written first with random content: the centre colour always,
  // and for a solid voxel each inner neighbour and each present edge plane.
  task automatic query_voxel(input logic [COORD_W-1:0] x, y, z);
    logic [COORD_W-1:0] nx, ny, nz;
    logic [COORD_W-1:0] px, py, pz;
    int                 v;
    int                 ps;
    bit                 on_edge;
    v = voxel_slot(x, y, z);
    if (!chunk_colour_set[v])
      send_beat(OP_WRITE_COLOUR, x, y, z, pick_colour(), SIDE_W'($urandom), 1'($urandom));
    if (chunk_colour[v] != 8'd0) begin
      for (int k = 0; k < SIDES; k++) begin
        on_edge = face_read(SIDE_W'(k), x, y, z, nx, ny, nz);
        if (on_edge) begin
          ps = plane_slot(SIDE_W'(k), x, y, z);
          if (sides_present[k] && !border_set[ps]) begin
            // The coordinate along the side's own axis is a don't-care.
            px = (k / 2 == 0) ? COORD_W'($urandom) : x;
            py = (k / 2 == 1) ? COORD_W'($urandom) : y;
            pz = (k / 2 == 2) ? COORD_W'($urandom) : z;
            send_beat(OP_WRITE_PLANE, px, py, pz, 8'($urandom), SIDE_W'(k),
                      1'($urandom));
          end
        end else if (!chunk_colour_set[voxel_slot(nx, ny, nz)]) begin
          send_beat(OP_WRITE_COLOUR, nx, ny, nz, pick_colour(), SIDE_W'($urandom),
                    1'($urandom));
        end
      end
    end
    send_beat(OP_QUERY, x, y, z, 8'($urandom), SIDE_W'($urandom), 1'($urandom));
  endtask

  // The sender holds off until every predicted result beat has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (pending_faces.size() != 0) @(posedge clk);
  endtask

  // The neighbour register is only written while the block is idle. Writes
  // leave no result behind, so the task waits after the drain to let the last one settle.
  task automatic set_present_sides(input logic [5:0] value);
    hold_until_drained();
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sides_present = value;
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // A solid voxel with six solid neighbours is fully enclosed. Emptying one
  // neighbour opens the +x face; the emptied voxel itself answers 1.
  task automatic test_enclosed_voxel();
    set_present_sides(6'h00);
    send_beat(OP_WRITE_COLOUR, 4'd5, 4'd5, 4'd5, 8'hA5, SIDE_PX, 1'b0);
    send_beat(OP_WRITE_COLOUR, 4'd4, 4'd5, 4'd5, 8'h01, SIDE_NX, 1'b1);
    send_beat(OP_WRITE_COLOUR, 4'd6, 4'd5, 4'd5, 8'hFF, SIDE_PY, 1'b0);
    send_beat(OP_WRITE_COLOUR, 4'd5, 4'd4, 4'd5, 8'h80, SIDE_NY, 1'b1);
    send_beat(OP_WRITE_COLOUR, 4'd5, 4'd6, 4'd5, 8'h7F, SIDE_PZ, 1'b0);
    send_beat(OP_WRITE_COLOUR, 4'd5, 4'd5, 4'd4, 8'h55, SIDE_NZ, 1'b1);
    send_beat(OP_WRITE_COLOUR, 4'd5, 4'd5, 4'd6, 8'hAA, SIDE_BAD_TOP, 1'b0);
    query_voxel(4'd5, 4'd5, 4'd5);
    send_beat(OP_WRITE_COLOUR, 4'd6, 4'd5, 4'd5, 8'h00, SIDE_PX, 1'b1);
    query_voxel(4'd5, 4'd5, 4'd5);
    query_voxel(4'd6, 4'd5, 4'd5);
  endtask

  // Two opposite corners with no neighbour chunks: the edge faces count as
  // covered. The low corner has empty inner neighbours, the high one solid.
  task automatic test_chunk_corners();
    send_beat(OP_WRITE_COLOUR, 4'd0, 4'd0, 4'd0, 8'hFF, SIDE_PX, 1'b0);
    send_beat(OP_WRITE_COLOUR, 4'd1, 4'd0, 4'd0, 8'h00, SIDE_PX, 1'b0);
    send_beat(OP_WRITE_COLOUR, 4'd0, 4'd1, 4'd0, 8'h00, SIDE_PX, 1'b0);
    send_beat(OP_WRITE_COLOUR, 4'd0, 4'd0, 4'd1, 8'h00, SIDE_PX, 1'b0);
    query_voxel(4'd0, 4'd0, 4'd0);
    send_beat(OP_WRITE_COLOUR, 4'd15, 4'd15, 4'd15, 8'hC3, SIDE_PX, 1'b0);
    send_beat(OP_WRITE_COLOUR, 4'd14, 4'd15, 4'd15, 8'h11, SIDE_PX, 1'b0);
    send_beat(OP_WRITE_COLOUR, 4'd15, 4'd14, 4'd15, 8'h22, SIDE_PX, 1'b0);
    send_beat(OP_WRITE_COLOUR, 4'd15, 4'd15, 4'd14, 8'h33, SIDE_PX, 1'b0);
    query_voxel(4'd15, 4'd15, 4'd15);
  endtask

  // One plane write per side, with a junk value on the side's own axis, then
  // a bad side code and the unused operation, both of which must be ignored.
  task automatic test_plane_and_ignored_writes();
    send_beat(OP_WRITE_PLANE, 4'd9,  4'd15, 4'd15, 8'h00, SIDE_PX, 1'b1);
    send_beat(OP_WRITE_PLANE, 4'd7,  4'd0,  4'd0,  8'hFF, SIDE_NX, 1'b1);
    send_beat(OP_WRITE_PLANE, 4'd15, 4'd3,  4'd15, 8'h00, SIDE_PY, 1'b0);
    send_beat(OP_WRITE_PLANE, 4'd0,  4'd12, 4'd0,  8'hFF, SIDE_NY, 1'b1);
    send_beat(OP_WRITE_PLANE, 4'd15, 4'd15, 4'd6,  8'h00, SIDE_PZ, 1'b1);
    send_beat(OP_WRITE_PLANE, 4'd0,  4'd0,  4'd15, 8'hFF, SIDE_NZ, 1'b1);
    send_beat(OP_WRITE_PLANE, 4'd15, 4'd15, 4'd15, 8'hFF, SIDE_BAD_LOW, 1'b0);
    send_beat(OP_UNUSED, 4'd5, 4'd5, 4'd5, 8'h00, SIDE_PX, 1'b1);
  endtask

  // With all six neighbour chunks present the corner faces follow the planes.
  task automatic test_present_neighbours();
    set_present_sides(6'h3F);
    query_voxel(4'd0, 4'd0, 4'd0);
    query_voxel(4'd15, 4'd15, 4'd15);
  endtask

  // Random mix of writes and queries. Each phase opens with a stretch where
  // neither side idles, and halfway through the sender waits for a full drain.
  task automatic random_traffic(input int target);
    int start;
    int r;
    bit drained;
    start   = useful_beats;
    drained = 1'b0;
    no_idle = 1'b1;
    while (useful_beats - start < target) begin
      if (useful_beats - start >= 50) no_idle = 1'b0;
      if (!drained && useful_beats - start >= target / 2) begin
        hold_until_drained();
        drained = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 35)
        send_beat(OP_WRITE_COLOUR, pick_coord(), pick_coord(), pick_coord(), pick_colour(),
                  SIDE_W'($urandom), 1'($urandom));
      else if (r < 55)
        send_beat(OP_WRITE_PLANE, pick_coord(), pick_coord(), pick_coord(), 8'($urandom),
                  SIDE_W'($urandom_range(SIDES - 1)), 1'($urandom));
      else if (r < 95)
        query_voxel(pick_coord(), pick_coord(), pick_coord());
      else if (r < 97)
        send_beat(OP_UNUSED, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                  8'($urandom), SIDE_W'($urandom), 1'($urandom));
      else
        send_beat(OP_WRITE_PLANE, COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), 8'($urandom),
                  ($urandom_range(1) != 0) ? SIDE_BAD_LOW : SIDE_BAD_TOP, 1'($urandom));
    end
    no_idle = 1'b0;
  endtask

  // Phases under several neighbour settings, both extremes among them.
  task automatic test_random_phases();
    logic [5:0] settings [7];
    settings[0] = 6'h00;
    settings[1] = 6'h3F;
    settings[2] = 6'(1 << $urandom_range(SIDES - 1));
    settings[3] = 6'($urandom);
    settings[4] = 6'h2A;
    settings[5] = 6'h15;
    settings[6] = 6'h3F;
    for (int p = 0; p < 7; p++) begin
      set_present_sides(settings[p]);
      hot_base = $urandom_range(EDGE - 4);
      random_traffic(265);
    end
  endtask

  initial begin
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    item_bus.valid        = 1'b0;
    item_bus.op           = OP_WRITE_COLOUR;
    item_bus.x_coord      = '0;
    item_bus.y_coord      = '0;
    item_bus.z_coord      = '0;
    item_bus.voxel_colour = '0;
    item_bus.side         = SIDE_PX;
    item_bus.plane_empty  = 1'b0;
    result_bus.ready      = 1'b0;
    sides_present         = '0;
    mismatches            = 0;
    useful_beats          = 0;
    cycle_count           = 0;
    ready_hold            = 0;
    hot_base              = 0;
    no_idle               = 1'b0;
    for (int i = 0; i < VOXELS; i++) begin
      chunk_colour[i]     = '0;
      chunk_colour_set[i] = 1'b0;
    end
    for (int i = 0; i < PLANE_BITS; i++) begin
      border_empty[i] = 1'b0;
      border_set[i]   = 1'b0;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_enclosed_voxel();
    test_chunk_corners();
    test_plane_and_ignored_writes();
    test_present_neighbours();
    test_random_phases();

    // Let the last results come back, then watch a little longer for strays.
    hold_until_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/vefm_pkg.sv
rtl/vefm_if.sv
rtl/vefm_ram.sv
rtl/voxel_exposed_face_mask.sv
rtl/vefm_checker.sv
tb/sv/tb_voxel_exposed_face_mask.sv
